>>> hdl/hap_pkg.sv
// Shared types and constants for the handle pool allocator.
// Depends on nothing; every other file in hdl refers to it by scoped names.
package hap_pkg;

  // Widths of the transaction fields.
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 2;

  // Number of handles a deallocate can name with an 8-bit handle field.
  localparam int HANDLE_SPACE = 1 << HANDLE_W;

  // Default pool size.
  localparam int POOL_HANDLES_DEF = 256;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_TRY   = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_NONE_FREE     = 2'd1,
    ST_NOT_ALLOCATED = 2'd2,
    ST_EXHAUSTED     = 2'd3
  } status_t;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

>>> hdl/hap_if.sv
// Valid/ready channel interfaces for the handle pool allocator.
// Depends on hap_pkg for the field widths.
interface hap_req_if;
  logic                         valid;
  logic                         ready;
  logic [hap_pkg::OP_W-1:0]     operation;
  logic [hap_pkg::HANDLE_W-1:0] handle_in;

  modport source (output valid, output operation, output handle_in, input ready);
  modport sink   (input valid, input operation, input handle_in, output ready);
endinterface

interface hap_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [hap_pkg::HANDLE_W-1:0] handle_out;
  logic [hap_pkg::STATUS_W-1:0] status;

  modport source (output valid, output handle_out, output status, input ready);
  modport sink   (input valid, input handle_out, input status, output ready);
endinterface

>>> hdl/handle_pool_allocator.sv
// A request is accepted in S_IDLE; its result is registered in S_EXEC once the output slot
// is free, and only then is a new request taken, as set by the read-then-write pass over the
// allocated-map memory and the free-list memory (one synchronous read, then one write).
// Reset: synchronous, active low; clears the control state, queue pointers, fresh-handle
// counter and the per-entry valid bits of the allocated map. The free-list
// memory is not cleared. Depends on hap_pkg and hap_if.
module handle_pool_allocator #(
  parameter int POOL_HANDLES = hap_pkg::POOL_HANDLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  hap_req_if.sink        in_ch,
  hap_rsp_if.source      out_ch
);

  // Only handles below the 8-bit handle space can ever be returned, so the map and
  // the free list need no more entries than that.
  localparam int MAP_DEPTH = (POOL_HANDLES < hap_pkg::HANDLE_SPACE) ?
                             POOL_HANDLES : hap_pkg::HANDLE_SPACE;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
  localparam int FRESH_W   = $clog2(POOL_HANDLES + 1);

  // Memories.
  logic                map_mem [MAP_DEPTH];
  logic [MAP_AW-1:0]   q_mem   [MAP_DEPTH];

  // Control and state registers.
  hap_pkg::state_t     state_r, state_nxt;
  logic [MAP_DEPTH-1:0] valid_r, valid_nxt;
  logic [MAP_AW-1:0]   head_r, head_nxt;
  logic [MAP_AW-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FRESH_W-1:0]  fresh_r, fresh_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request registers and memory read data.
  hap_pkg::op_t        op_r;
  logic [MAP_AW-1:0]   hidx_r;
  logic                in_range_r;
  logic                map_rd_r;
  logic [MAP_AW-1:0]   q_rd_r;

  // Output payload registers.
  logic [hap_pkg::HANDLE_W-1:0] hout_r, hout_nxt;
  hap_pkg::status_t    status_r, status_nxt;

  // Handshake and write controls.
  logic                accept;
  logic                exec_fire;
  logic                in_ready;
  logic                in_range;
  logic                alloc_hit;
  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  logic                map_wdata;
  logic                q_we;

  assign in_range = 32'(in_ch.handle_in) < 32'(POOL_HANDLES);
  assign accept   = in_ch.valid && in_ready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hap_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = hap_pkg::S_EXEC;
        end
      end
      hap_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_nxt = hap_pkg::S_IDLE;
        end
      end
      default: state_nxt = hap_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: take a request when idle, finish it once the output slot is free.
  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      hap_pkg::S_IDLE: in_ready  = 1'b1;
      hap_pkg::S_EXEC: exec_fire = !out_valid_r || out_ch.ready;
      default: begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  // An entry that has not been written since reset reads as free.
  assign alloc_hit = valid_r[hidx_r] & map_rd_r;

  // Execute the request against the read data and work out the writes.
  always_comb begin
    hout_nxt   = '0;
    status_nxt = hap_pkg::ST_OK;
    map_we     = 1'b0;
    map_waddr  = hidx_r;
    map_wdata  = 1'b0;
    q_we       = 1'b0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    fresh_nxt  = fresh_r;
    case (op_r)
      hap_pkg::OP_ALLOC, hap_pkg::OP_TRY: begin
        if (count_r != '0) begin
          // Reuse the oldest returned handle.
          hout_nxt  = hap_pkg::HANDLE_W'(q_rd_r);
          map_we    = 1'b1;
          map_waddr = q_rd_r;
          map_wdata = 1'b1;
          head_nxt  = (head_r == MAP_AW'(MAP_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end else if (op_r == hap_pkg::OP_TRY) begin
          status_nxt = hap_pkg::ST_NONE_FREE;
        end else if (fresh_r < FRESH_W'(POOL_HANDLES)) begin
          // Issue a never-used handle; only those that can be returned are tracked.
          hout_nxt  = hap_pkg::HANDLE_W'(fresh_r);
          map_we    = fresh_r < FRESH_W'(MAP_DEPTH);
          map_waddr = MAP_AW'(fresh_r);
          map_wdata = 1'b1;
          fresh_nxt = fresh_r + 1'b1;
        end else begin
          status_nxt = hap_pkg::ST_EXHAUSTED;
        end
      end
      hap_pkg::OP_FREE: begin
        if (in_range_r && alloc_hit) begin
          map_we    = 1'b1;
          map_waddr = hidx_r;
          map_wdata = 1'b0;
          if (count_r < CNT_W'(MAP_DEPTH)) begin
            q_we      = 1'b1;
            tail_nxt  = (tail_r == MAP_AW'(MAP_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else begin
          status_nxt = hap_pkg::ST_NOT_ALLOCATED;
        end
      end
      default: status_nxt = hap_pkg::ST_OK;
    endcase
  end

  // Valid bits of the allocated map and the output valid flag.
  always_comb begin
    valid_nxt = valid_r;
    if (exec_fire && map_we) begin
      valid_nxt[map_waddr] = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hap_pkg::S_IDLE;
      valid_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
        fresh_r <= fresh_nxt;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= hap_pkg::op_t'(in_ch.operation);
      hidx_r     <= MAP_AW'(in_ch.handle_in);
      in_range_r <= in_range;
    end
    if (exec_fire) begin
      hout_r   <= hout_nxt;
      status_r <= status_nxt;
    end
  end

  // Allocated-map memory: read at the request's handle, written on completion.
  always_ff @(posedge clk) begin
    if (accept) begin
      map_rd_r <= map_mem[MAP_AW'(in_ch.handle_in)];
    end
    if (exec_fire && map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  // Free-list memory: read at the head, written at the tail.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_rd_r <= q_mem[head_r];
    end
    if (exec_fire && q_we) begin
      q_mem[tail_r] <= hidx_r;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.handle_out = hout_r;
  assign out_ch.status     = status_r;

endmodule

>>> dv/tb_handle_pool_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for handle_pool_allocator: directed and random handle traffic.
// Depends on hap_pkg and the channel interfaces in hap_if; checks against an in-bench predictor.
module tb_handle_pool_allocator;

  localparam int POOL        = hap_pkg::POOL_HANDLES_DEF;
  localparam int RANDOM_REQS = 1780;
  localparam int TAIL_REQS   = 150;
  localparam int SETTLE      = 12;

  // The operation code that the block ignores.
  localparam logic [hap_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Predictor copies: one steers stimulus generation, one checks the block.
  localparam int PLAN_COPY  = 0;
  localparam int CHECK_COPY = 1;

  // Traffic mixes for the random part.
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  typedef struct packed {
    logic [hap_pkg::OP_W-1:0]     op;
    logic [hap_pkg::HANDLE_W-1:0] handle;
  } req_item_t;

  typedef struct packed {
    logic [hap_pkg::HANDLE_W-1:0] handle;
    hap_pkg::status_t             status;
  } grant_t;

  logic clk;
  logic rst_n;

  hap_req_if req_ch ();
  hap_rsp_if rsp_ch ();

  handle_pool_allocator #(.POOL_HANDLES(POOL)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // Pool state, one copy per use.
  bit                         held_map   [2][POOL];
  bit [hap_pkg::HANDLE_W-1:0] free_ring  [2][POOL];
  bit [hap_pkg::HANDLE_W-1:0] ring_head  [2];
  bit [hap_pkg::HANDLE_W-1:0] ring_tail  [2];
  bit [8:0]                   ring_count [2];
  bit [8:0]                   fresh_next [2];

  req_item_t stim_q[$];
  grant_t    pending_grants[$];

  int err_count;
  int op_tally [4];
  int st_tally [4];
  int send_gap;
  int rsp_stall;
  bit send_idle_on;
  bit rsp_idle_on;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Applies one request to a copy of the pool state and returns its grant.
  function automatic void compute_grant(input int cp, input logic [hap_pkg::OP_W-1:0] op,
                                        input logic [hap_pkg::HANDLE_W-1:0] hin,
                                        output logic [hap_pkg::HANDLE_W-1:0] hout,
                                        output hap_pkg::status_t st);
    bit [hap_pkg::HANDLE_W-1:0] h;
    hout = '0;
    st   = hap_pkg::ST_OK;
    if (op == hap_pkg::OP_ALLOC || op == hap_pkg::OP_TRY) begin
      if (ring_count[cp] != 0) begin
        // Oldest freed handle goes out first.
        h = free_ring[cp][ring_head[cp]];
        ring_head[cp] = hap_pkg::HANDLE_W'((int'(ring_head[cp]) + 1) % POOL);
        ring_count[cp] = ring_count[cp] - 9'd1;
        held_map[cp][h] = 1'b1;
        hout = h;
      end else if (op == hap_pkg::OP_TRY) begin
        st = hap_pkg::ST_NONE_FREE;
      end else if (int'(fresh_next[cp]) < POOL) begin
        h = fresh_next[cp][hap_pkg::HANDLE_W-1:0];
        held_map[cp][h] = 1'b1;
        fresh_next[cp] = fresh_next[cp] + 9'd1;
        hout = h;
      end else begin
        st = hap_pkg::ST_EXHAUSTED;
      end
    end else if (op == hap_pkg::OP_FREE) begin
      if (int'(hin) < POOL && held_map[cp][hin]) begin
        held_map[cp][hin] = 1'b0;
        if (int'(ring_count[cp]) < POOL) begin
          free_ring[cp][ring_tail[cp]] = hin;
          ring_tail[cp] = hap_pkg::HANDLE_W'((int'(ring_tail[cp]) + 1) % POOL);
          ring_count[cp] = ring_count[cp] + 9'd1;
        end
      end else begin
        st = hap_pkg::ST_NOT_ALLOCATED;
      end
    end
  endfunction

  // Queues one request and advances the planning copy so later frees can target held handles.
  task automatic plan_req(input logic [hap_pkg::OP_W-1:0] op,
                          input logic [hap_pkg::HANDLE_W-1:0] h,
                          output hap_pkg::status_t st);
    logic [hap_pkg::HANDLE_W-1:0] unused_h;
    req_item_t item;
    item.op     = op;
    item.handle = h;
    stim_q.push_back(item);
    compute_grant(PLAN_COPY, op, h, unused_h, st);
  endtask

  // Returns a handle that the planning copy holds, or a random one when none is held.
  function automatic logic [hap_pkg::HANDLE_W-1:0] pick_held();
    int start;
    int idx;
    start = $urandom_range(0, POOL - 1);
    for (int k = 0; k < POOL; k++) begin
      idx = (start + k) % POOL;
      if (held_map[PLAN_COPY][idx]) return hap_pkg::HANDLE_W'(idx);
    end
    return hap_pkg::HANDLE_W'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // Request driver: predicts each accepted transaction, then presents the next item.
  always @(posedge clk) begin : drive_req
    logic [hap_pkg::HANDLE_W-1:0] exp_h;
    hap_pkg::status_t             exp_st;
    req_item_t                    nxt;
    grant_t                       g;
    if (!rst_n) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= hap_pkg::OP_ALLOC;
      req_ch.handle_in <= '0;
      send_gap         <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        compute_grant(CHECK_COPY, req_ch.operation, req_ch.handle_in, exp_h, exp_st);
        g.handle = exp_h;
        g.status = exp_st;
        pending_grants.push_back(g);
        op_tally[req_ch.operation]++;
        st_tally[exp_st]++;
      end
      // A new item goes out only once the current one has been taken.
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= nxt.op;
          req_ch.handle_in <= nxt.handle;
          if (send_idle_on && stim_q.size() > TAIL_REQS && $urandom_range(0, 99) < 20)
            send_gap <= $urandom_range(1, 15);
          if ($urandom_range(0, 99) == 0) send_idle_on <= !send_idle_on;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted transaction and applies backpressure in bursts.
  always @(posedge clk) begin : watch_rsp
    grant_t g;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected result handle %0d status %0d",
                                    rsp_ch.handle_out, rsp_ch.status));
        end else begin
          g = pending_grants.pop_front();
          if (rsp_ch.handle_out !== g.handle)
            report_mismatch($sformatf("handle_out %0d, expected %0d",
                                      rsp_ch.handle_out, g.handle));
          if (rsp_ch.status !== g.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      rsp_ch.status, g.status.name()));
        end
      end
      if (rsp_stall != 0) begin
        rsp_stall    <= rsp_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_idle_on && stim_q.size() > TAIL_REQS && $urandom_range(0, 99) < 12) begin
        rsp_stall    <= $urandom_range(0, 14);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) == 0) rsp_idle_on <= !rsp_idle_on;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : main_flow
    hap_pkg::status_t             st;
    mix_t                         mix;
    int                           len;
    int                           r;
    int                           j;
    bit                           swept;
    logic [hap_pkg::HANDLE_W-1:0] tmp;
    logic [hap_pkg::HANDLE_W-1:0] held_list[$];

    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = hap_pkg::OP_ALLOC;
    req_ch.handle_in = '0;
    rsp_ch.ready     = 1'b0;
    send_idle_on     = 1'b1;
    rsp_idle_on      = 1'b1;
    err_count        = 0;
    swept            = 1'b0;

    // Directed part: empty pool errors, the ignored code, FIFO reuse order and double free.
    plan_req(hap_pkg::OP_TRY, 8'hFF, st);
    plan_req(hap_pkg::OP_FREE, 8'h00, st);
    plan_req(hap_pkg::OP_FREE, 8'hFF, st);
    plan_req(OP_UNUSED, 8'hFF, st);
    plan_req(OP_UNUSED, 8'h00, st);
    plan_req(hap_pkg::OP_ALLOC, 8'h00, st);
    plan_req(hap_pkg::OP_ALLOC, 8'hFF, st);
    plan_req(hap_pkg::OP_ALLOC, 8'hA5, st);
    plan_req(hap_pkg::OP_FREE, 8'h01, st);
    plan_req(hap_pkg::OP_FREE, 8'h01, st);
    plan_req(hap_pkg::OP_FREE, 8'h00, st);
    plan_req(hap_pkg::OP_TRY, 8'h5A, st);
    plan_req(hap_pkg::OP_ALLOC, 8'h00, st);
    plan_req(hap_pkg::OP_ALLOC, 8'h00, st);
    plan_req(hap_pkg::OP_FREE, 8'h02, st);
    plan_req(hap_pkg::OP_ALLOC, 8'h00, st);
    plan_req(hap_pkg::OP_TRY, 8'h00, st);
    plan_req(hap_pkg::OP_FREE, 8'h03, st);
    plan_req(hap_pkg::OP_ALLOC, 8'h00, st);

    // Random part: bursts of different mixes, with one sweep to exhaustion and a full free list.
    while (stim_q.size() < RANDOM_REQS) begin
      if (!swept && stim_q.size() > 700) begin
        swept = 1'b1;
        do plan_req(hap_pkg::OP_ALLOC, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
        while (st != hap_pkg::ST_EXHAUSTED);
        plan_req(hap_pkg::OP_TRY, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
        plan_req(hap_pkg::OP_ALLOC, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
        // Return every handle in shuffled order so the free list fills up.
        held_list.delete();
        for (int k = 0; k < POOL; k++)
          if (held_map[PLAN_COPY][k]) held_list.push_back(hap_pkg::HANDLE_W'(k));
        for (int k = held_list.size() - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = held_list[k];
          held_list[k] = held_list[j];
          held_list[j] = tmp;
        end
        foreach (held_list[k]) plan_req(hap_pkg::OP_FREE, held_list[k], st);
        plan_req(hap_pkg::OP_FREE, held_list[0], st);
        continue;
      end
      mix = mix_t'($urandom_range(0, 2));
      len = $urandom_range(60, 200);
      // Keep the total close to the intended item count.
      if (len > RANDOM_REQS - stim_q.size()) len = RANDOM_REQS - stim_q.size();
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          // Noise: the ignored code or a free of an arbitrary handle.
          if (r < 2) plan_req(OP_UNUSED, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
          else plan_req(hap_pkg::OP_FREE, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
        end else begin
          r = $urandom_range(0, 99);
          if ((mix == MIX_FILL && r < 70) || (mix == MIX_BALANCED && r < 38) ||
              (mix == MIX_DRAIN && r < 18))
            plan_req(hap_pkg::OP_ALLOC, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
          else if ((mix == MIX_FILL && r < 82) || (mix == MIX_BALANCED && r < 58) ||
                   (mix == MIX_DRAIN && r < 33))
            plan_req(hap_pkg::OP_TRY, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
          else if ($urandom_range(0, 99) < 90)
            plan_req(hap_pkg::OP_FREE, pick_held(), st);
          else
            plan_req(hap_pkg::OP_FREE, hap_pkg::HANDLE_W'($urandom_range(0, 255)), st);
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d alloc, %0d try, %0d free and %0d ignored-code requests",
             op_tally[hap_pkg::OP_ALLOC], op_tally[hap_pkg::OP_TRY],
             op_tally[hap_pkg::OP_FREE], op_tally[OP_UNUSED]);
    $display("results: %0d ok, %0d none free, %0d not allocated, %0d exhausted; %0d errors",
             st_tally[hap_pkg::ST_OK], st_tally[hap_pkg::ST_NONE_FREE],
             st_tally[hap_pkg::ST_NOT_ALLOCATED], st_tally[hap_pkg::ST_EXHAUSTED], err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("timeout with %0d requests unsent and %0d results outstanding",
             stim_q.size(), pending_grants.size());
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
hdl/hap_pkg.sv
hdl/hap_if.sv
hdl/handle_pool_allocator.sv
dv/tb_handle_pool_allocator.sv
